[src/fcds_pkg.sv]
// shared types and constants for the flash clock divider search
package fcds_pkg;

  localparam int unsigned FreqW = 32;
  localparam int unsigned ErrW  = FreqW + 1;
  localparam int unsigned CodeW = 7;
  localparam int unsigned IdxW  = 8;

  localparam logic [FreqW-1:0] MinFreqReset = 32'd150000;
  localparam logic [FreqW-1:0] MaxFreqReset = 32'd200000;

  // configuration register indexes
  localparam logic [IdxW-1:0] RegMinFreq = 8'd0;
  localparam logic [IdxW-1:0] RegMaxFreq = 8'd1;

  // item flowing down the operand lane
  typedef struct packed {
    logic             valid;
    logic [FreqW-1:0] src;
  } op_t;

  // running best flowing down the result lane
  typedef struct packed {
    logic             valid;
    logic [ErrW-1:0]  err;
    logic [CodeW-1:0] best;
    logic             have;
  } acc_t;

  // window settings broadcast to every cell
  typedef struct packed {
    logic [FreqW-1:0] lo;
    logic [FreqW-1:0] hi;
    logic [FreqW-1:0] target;
  } win_t;

endpackage

[src/fcds_cell.sv]
// one cell of the search chain: evaluates a single divider code
module fcds_cell #(
  parameter int CODE = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fcds_pkg::win_t win,
  input  fcds_pkg::op_t  op_in,
  input  fcds_pkg::acc_t acc_in,
  output fcds_pkg::op_t  op_out,
  output fcds_pkg::acc_t acc_out
);
  import fcds_pkg::*;

  localparam int K        = (CODE % 64) + 1;
  localparam bit PRESCALE = ((CODE / 64) % 2) == 1;
  localparam bit DEAD     = CODE >= 128;
  localparam logic [FreqW-1:0] Magic   = 32'((64'd1 << 32) / K);
  localparam logic [6:0]       KVal    = 7'(K);
  localparam logic [CodeW-1:0] CodeLow = 7'(CODE % 128);

  op_t  op_r;
  acc_t acc_r;
  acc_t acc_nxt;

  logic [FreqW-1:0]   base;
  logic [2*FreqW-1:0] prod;
  logic [FreqW+6:0]   qk_full;
  logic [FreqW-1:0]   rem;
  logic [FreqW-1:0]   f_nxt;
  logic [FreqW-1:0]   d_nxt;
  logic               win_nxt;

  logic [FreqW-1:0] s1_q0_r, s1_base_r;
  logic [FreqW-1:0] s2_q0_r, s2_base_r, s2_qk_r;
  logic [FreqW-1:0] s3_f_r;
  logic [FreqW-1:0] s4_d_r;
  logic             s4_win_r;

  // reciprocal estimate is exact or one low
  always_comb begin
    base = PRESCALE ? {3'b000, op_in.src[FreqW-1:3]} : op_in.src;
    prod = base * Magic;
  end

  always_comb begin
    qk_full = s1_q0_r * KVal;
    rem     = s2_base_r - s2_qk_r;
    f_nxt   = s2_q0_r + {31'd0, (rem >= {25'd0, KVal})};
    win_nxt = !DEAD && (s3_f_r > win.lo) && (s3_f_r <= win.hi);
    d_nxt   = (s3_f_r >= win.target) ? (s3_f_r - win.target) : (win.target - s3_f_r);
  end

  always_ff @(posedge clk) begin
    s1_q0_r   <= (K == 1) ? base : prod[2*FreqW-1:FreqW];
    s1_base_r <= base;
    s2_q0_r   <= s1_q0_r;
    s2_base_r <= s1_base_r;
    s2_qk_r   <= qk_full[FreqW-1:0];
    s3_f_r    <= f_nxt;
    s4_d_r    <= d_nxt;
    s4_win_r  <= win_nxt;
  end

  // result lane trails the operand lane by the s1 to s4 stage registers
  always_comb begin
    acc_nxt = acc_in;
    if (s4_win_r && ({1'b0, s4_d_r} < acc_in.err)) begin
      acc_nxt.err  = {1'b0, s4_d_r};
      acc_nxt.best = CodeLow;
      acc_nxt.have = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r.valid  <= 1'b0;
      acc_r.valid <= 1'b0;
    end else begin
      op_r.valid  <= op_in.valid;
      acc_r.valid <= acc_in.valid;
    end
    op_r.src   <= op_in.src;
    acc_r.err  <= acc_nxt.err;
    acc_r.best <= acc_nxt.best;
    acc_r.have <= acc_nxt.have;
  end

  assign op_out  = op_r;
  assign acc_out = acc_r;

endmodule

[src/flash_clock_divider_search_core.sv]
// top level: flash clock divider search as a chain of one cell per divider code
// results strobe after the input register, the lag registers and each cell's result register
// throughput: one item per cycle while busy is low; each cell runs a four-stage pipeline with a reciprocal divider
// register writes wait until no item is in flight; busy is high while one waits
// reset: synchronous, active low; loads the default bounds, busy high until it ends
// results cannot be stalled by the receiver
module flash_clock_divider_search_core #(
  parameter int DIVIDER_CODES = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [fcds_pkg::FreqW-1:0] in_source_clock_freq,
  output logic                       out_valid,
  output logic [fcds_pkg::CodeW-1:0] out_divider_code,
  output logic                       out_found,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fcds_pkg::IdxW-1:0]  cfg_index,
  input  logic [fcds_pkg::FreqW-1:0] cfg_data
);
  import fcds_pkg::*;

  localparam int Latency = DIVIDER_CODES + 5;
  localparam int PendW   = $clog2(Latency + 1);

  logic             busy_r;
  logic [FreqW-1:0] min_r, max_r;
  logic [FreqW-1:0] target_r;
  logic [ErrW-1:0]  err_init_r;
  logic [FreqW:0]   bound_sum;
  logic [FreqW-1:0] bound_diff;
  op_t              op_r;
  logic [3:0]       lag_r;
  win_t             win;
  logic [PendW-1:0] pend_r;
  logic             item_acc;

  op_t  op_chain  [DIVIDER_CODES+1];
  acc_t acc_chain [DIVIDER_CODES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // a waiting register write holds off new items
  assign busy      = busy_r || cfg_valid;
  assign cfg_ready = !busy_r && (pend_r == '0);
  assign item_acc  = start && !busy;

  // items accepted and not yet strobed out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (item_acc && !out_valid) begin
      pend_r <= pend_r + 1'b1;
    end else if (!item_acc && out_valid) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MinFreqReset;
      max_r <= MaxFreqReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegMinFreq: min_r <= cfg_data;
        RegMaxFreq: max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // midpoint and starting error bound are registered from the bounds
  always_comb begin
    bound_sum  = {1'b0, min_r} + {1'b0, max_r};
    bound_diff = max_r - min_r;
  end

  always_ff @(posedge clk) begin
    target_r   <= bound_sum[FreqW:1];
    err_init_r <= (max_r > min_r) ? {bound_diff, 1'b0} : '0;
  end

  assign win.lo     = min_r;
  assign win.hi     = max_r;
  assign win.target = target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r.valid <= 1'b0;
      lag_r      <= '0;
    end else begin
      op_r.valid <= item_acc;
      lag_r      <= {lag_r[2:0], op_r.valid};
    end
    op_r.src <= in_source_clock_freq;
  end

  always_comb begin
    op_chain[0]       = op_r;
    acc_chain[0].valid = lag_r[3];
    acc_chain[0].err   = err_init_r;
    acc_chain[0].best  = '0;
    acc_chain[0].have  = 1'b0;
  end

  for (genvar gi = 0; gi < DIVIDER_CODES; gi++) begin : g_cell
    fcds_cell #(
      .CODE(gi)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .win    (win),
      .op_in  (op_chain[gi]),
      .acc_in (acc_chain[gi]),
      .op_out (op_chain[gi+1]),
      .acc_out(acc_chain[gi+1])
    );
  end

  assign out_valid        = acc_chain[DIVIDER_CODES].valid;
  assign out_divider_code = acc_chain[DIVIDER_CODES].have ?
                            acc_chain[DIVIDER_CODES].best : '0;
  assign out_found        = acc_chain[DIVIDER_CODES].have;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##Latency out_valid)
    else $error("result missing after an accepted item");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_divider_code == '0))
    else $error("nonzero code with nothing found");

  a_found_window: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (max_r > min_r))
    else $error("code found with an empty window");

endmodule
